// File: design/ita_pkg.sv
`default_nettype none

package ita_pkg;

  // default width of the signed input value
  localparam int unsigned ValueWidthDef = 32;

  // radix register
  localparam int unsigned RadixW = 6;
  localparam logic [RadixW-1:0] RadixReset = RadixW'(10);
  localparam logic [RadixW-1:0] RadixMin = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax = RadixW'(36);

  // character codes
  localparam int unsigned CharW = 7;
  localparam logic [CharW-1:0] CharMinus = 7'h2d;
  localparam logic [CharW-1:0] CharZero = 7'h30;
  localparam logic [CharW-1:0] CharLowerA = 7'h61;
  localparam logic [CharW-1:0] CharNone = 7'h00;

  // quotient bits retired per cycle by the divider
  localparam int unsigned DivSteps = 8;

  function automatic logic [CharW-1:0] digit_char(input logic [RadixW-1:0] d);
    logic [CharW-1:0] dx;
    dx = CharW'(d);
    if (d < RadixW'(10)) begin
      digit_char = CharZero + dx;
    end else begin
      digit_char = CharLowerA + dx - CharW'(10);
    end
  endfunction

endpackage

`default_nettype wire

// File: design/int_to_ascii_radix.sv
// a request is taken in idle; the divider then builds each digit from CEIL(VALUE_WIDTH/8) chunks
//   of the dividend, and characters go out one per cycle while the receiver does not stall
// one number at a time; the next request is taken once the last character is loaded
//   into the output register
// reset: radix returns to 10, sequencer idle, output register empty
`default_nettype none

module int_to_ascii_radix #(
  parameter int unsigned VALUE_WIDTH = ita_pkg::ValueWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // number request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0]       value_i,
  // radix register write
  input  logic                                radix_we_i,
  input  logic [ita_pkg::RadixW-1:0]          radix_i,
  // character channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ita_pkg::CharW-1:0]           char_code_o,
  output logic                                last_char_o,
  output logic                                bad_radix_o
);

  import ita_pkg::*;

  // dividend padded to whole chunks of DivSteps bits; leading zeros only add zero quotient bits
  localparam int unsigned Chunks = (VALUE_WIDTH + DivSteps - 1) / DivSteps;
  localparam int unsigned PadW = Chunks * DivSteps;
  localparam int unsigned CntW = (Chunks > 1) ? $clog2(Chunks) : 1;
  // a base 2 magnitude of the most negative value needs VALUE_WIDTH digits
  localparam int unsigned NdigW = $clog2(VALUE_WIDTH + 1);

  // sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;
  localparam logic [1:0] StBad  = 2'd3;

  logic [1:0]             state_q;
  logic [CntW-1:0]        cnt_q;       // chunk within the current digit
  logic [NdigW-1:0]       ndig_q;      // digits held on the stack
  logic                   neg_q;       // minus sign still to be sent
  logic                   out_valid_q;
  logic [RadixW-1:0]      radix_q;

  logic [RadixW-1:0]      base_q;      // radix captured with the request
  logic [PadW-1:0]        num_q;       // dividend, shifting out as quotient shifts in
  logic [RadixW-1:0]      rem_q;       // partial remainder, always below the base
  logic [RadixW-1:0]      dig_q [VALUE_WIDTH];  // digit stack, top at entry 0
  logic [CharW-1:0]       char_q;
  logic                   last_q;
  logic                   bad_q;

  logic                   accept;
  logic                   radix_bad;
  logic                   out_free;
  logic                   div_last;
  logic                   div_done;
  logic                   emit_go;
  logic                   bad_go;
  logic [VALUE_WIDTH-1:0] mag;
  logic [PadW-1:0]        div_num;
  logic [RadixW-1:0]      div_rem;
  logic [RadixW:0]        trial;

  assign accept    = in_valid_i && (state_q == StIdle);
  assign radix_bad = !(radix_q inside {[RadixMin:RadixMax]});
  assign out_free  = !out_valid_q || !out_stall_i;
  assign div_last  = (state_q == StDiv) && (cnt_q == CntW'(Chunks - 1));
  assign div_done  = div_last && (div_num == '0);
  assign emit_go   = (state_q == StEmit) && out_free;
  assign bad_go    = (state_q == StBad) && out_free;

  // magnitude; the most negative value maps onto 2^(VALUE_WIDTH-1), which still fits unsigned
  assign mag = value_i[VALUE_WIDTH-1] ? (~$unsigned(value_i) + 1'b1) : $unsigned(value_i);

  // shared divider: restoring division, DivSteps quotient bits per cycle on a 6-bit remainder
  always_comb begin
    div_num = num_q;
    div_rem = rem_q;
    trial   = '0;
    for (int j = 0; j < DivSteps; j++) begin
      trial   = {div_rem, div_num[PadW-1]};
      div_num = {div_num[PadW-2:0], 1'b0};
      if (trial >= {1'b0, base_q}) begin
        trial      = trial - {1'b0, base_q};
        div_num[0] = 1'b1;
      end
      div_rem = trial[RadixW-1:0];
    end
  end

  // sequencer and handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      ndig_q      <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      radix_q     <= RadixReset;
    end else begin
      if (radix_we_i) begin
        radix_q <= radix_i;
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= radix_bad ? StBad : StDiv;
            cnt_q   <= '0;
            ndig_q  <= '0;
            neg_q   <= value_i[VALUE_WIDTH-1];
          end
        end
        StDiv: begin
          cnt_q <= div_last ? '0 : cnt_q + 1'b1;
          if (div_last) begin
            ndig_q <= ndig_q + 1'b1;
          end
          if (div_done) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (emit_go) begin
            if (neg_q) begin
              neg_q <= 1'b0;
            end else begin
              ndig_q <= ndig_q - 1'b1;
              if (ndig_q == NdigW'(1)) begin
                state_q <= StIdle;
              end
            end
          end
        end
        StBad: begin
          if (bad_go) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase

      // output register frees on take, refills from the sequencer
      if (emit_go || bad_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      base_q <= radix_q;
      num_q  <= PadW'(mag);
      rem_q  <= '0;
    end

    if (state_q == StDiv) begin
      num_q <= div_num;
      if (div_last) begin
        // digit complete: push remainder, restart on the quotient
        rem_q <= '0;
        dig_q[0] <= div_rem;
        for (int i = 1; i < VALUE_WIDTH; i++) begin
          dig_q[i] <= dig_q[i-1];
        end
      end else begin
        rem_q <= div_rem;
      end
    end

    if (emit_go) begin
      bad_q <= 1'b0;
      if (neg_q) begin
        char_q <= CharMinus;
        last_q <= 1'b0;
      end else begin
        // most significant digit was pushed last, so it sits on top
        char_q <= digit_char(dig_q[0]);
        last_q <= (ndig_q == NdigW'(1));
        for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
          dig_q[i] <= dig_q[i+1];
        end
      end
    end

    if (bad_go) begin
      char_q <= CharNone;
      last_q <= 1'b1;
      bad_q  <= 1'b1;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;
  assign bad_radix_o = bad_q;

endmodule

`default_nettype wire

// File: test/int_to_ascii_radix_chk.sv
module int_to_ascii_radix_chk #(
  parameter int unsigned VALUE_WIDTH = ita_pkg::ValueWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic signed [VALUE_WIDTH-1:0]  value_i,
  input  logic                           radix_we_i,
  input  logic [ita_pkg::RadixW-1:0]     radix_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [ita_pkg::CharW-1:0]      char_code_i,
  input  logic                           last_char_i,
  input  logic                           bad_radix_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    chars_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ita_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
    logic             bad;
  } text_char_t;

  text_char_t        text_due[$];
  text_char_t        due_c;
  logic [RadixW-1:0] base_q = RadixReset;
  int unsigned       mismatches = 0;
  int unsigned       due_count = 0;

  assign fail_count_o = mismatches;
  assign chars_due_o  = due_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] character check: %s", $time, what);
    mismatches++;
  endtask

  // queues the text of one number, most significant character first
  function automatic void spell_number(input logic signed [VALUE_WIDTH-1:0] num,
                                       input logic [RadixW-1:0] base);
    logic [VALUE_WIDTH-1:0] mag;
    logic [RadixW-1:0]      digits[VALUE_WIDTH];
    int unsigned            n;
    logic [CharW-1:0]       ch;
    if (base < RadixMin || base > RadixMax) begin
      text_due.push_back('{code: CharNone, last: 1'b1, bad: 1'b1});
      return;
    end
    // two's complement negate gives the exact magnitude of the most negative value
    mag = num[VALUE_WIDTH-1] ? (~num + 1'b1) : num;
    n = 0;
    do begin
      digits[n] = RadixW'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0);
    if (num[VALUE_WIDTH-1]) begin
      text_due.push_back('{code: CharMinus, last: 1'b0, bad: 1'b0});
    end
    for (int i = int'(n) - 1; i >= 0; i--) begin
      if (digits[i] < RadixW'(10)) begin
        ch = CharZero + CharW'(digits[i]);
      end else begin
        ch = CharLowerA + CharW'(digits[i]) - CharW'(10);
      end
      text_due.push_back('{code: ch, last: (i == 0), bad: 1'b0});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q = RadixReset;
      text_due.delete();
      due_count = 0;
    end else begin
      if (radix_we_i) begin
        base_q = radix_i;
      end
      // retire before queueing, so a fresh request never meets its own output
      if (out_valid_i && !out_stall_i) begin
        if (text_due.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h", char_code_i));
        end else begin
          due_c = text_due.pop_front();
          if (char_code_i !== due_c.code) begin
            report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                      char_code_i, due_c.code));
          end
          if (last_char_i !== due_c.last) begin
            report_mismatch($sformatf("last_char %b, want %b", last_char_i, due_c.last));
          end
          if (bad_radix_i !== due_c.bad) begin
            report_mismatch($sformatf("bad_radix %b, want %b", bad_radix_i, due_c.bad));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        spell_number(value_i, base_q);
      end
      due_count = text_due.size();
    end
  end

endmodule

// File: test/int_to_ascii_radix_tb.sv
module int_to_ascii_radix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ita_pkg::*;

  localparam int unsigned ValueW        = ValueWidthDef;
  localparam int unsigned RandomItems   = 500;
  // long receiver hold-off, well past one base 2 number so the block backs up
  localparam int unsigned HoldCycles    = 400;
  // settle time after the last character, about one slow number
  localparam int unsigned DrainCycles   = 200;
  // silence limit: the hold-off plus a base 2 conversion plus the longest gaps, several times over
  localparam int unsigned WatchdogLimit = 5000;

  localparam logic [ValueW-1:0] NumMax = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic [ValueW-1:0] NumMin = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic [ValueW-1:0] NumNeg1 = {ValueW{1'b1}};

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [ValueW-1:0] value;
  logic                     radix_we;
  logic [RadixW-1:0]        radix;
  logic                     out_valid;
  logic                     out_stall;
  logic [CharW-1:0]         char_code;
  logic                     last_char;
  logic                     bad_radix;

  int unsigned mismatches;
  int unsigned chars_due;

  // set by the request driver, read by the character receiver
  logic no_gaps  = 1'b0;
  logic hold_off = 1'b0;

  always #10 clk = ~clk;

  int_to_ascii_radix #(
    .VALUE_WIDTH (ValueW)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (value),
    .radix_we_i  (radix_we),
    .radix_i     (radix),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .char_code_o (char_code),
    .last_char_o (last_char),
    .bad_radix_o (bad_radix)
  );

  int_to_ascii_radix_chk #(
    .VALUE_WIDTH (ValueW)
  ) u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .value_i      (value),
    .radix_we_i   (radix_we),
    .radix_i      (radix),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .char_code_i  (char_code),
    .last_char_i  (last_char),
    .bad_radix_i  (bad_radix),
    .fail_count_o (mismatches),
    .chars_due_o  (chars_due)
  );

  // idle length: mostly none or a few cycles, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // number mix: full range, small magnitudes, extremes, powers of two and shortened words
  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    int unsigned       k;
    case ($urandom_range(0, 9))
      5, 6: begin
        v = ValueW'($urandom_range(0, 40));
      end
      7: begin
        case ($urandom_range(0, 3))
          0: v = NumMin;
          1: v = NumMax;
          2: v = NumNeg1;
          default: v = '0;
        endcase
        return v;
      end
      8: begin
        k = $urandom_range(0, ValueW - 2);
        v = (ValueW'(1) << k) - ValueW'($urandom_range(0, 1));
      end
      9: begin
        v = ValueW'({$urandom(), $urandom()}) >> $urandom_range(1, ValueW - 1);
      end
      default: begin
        return ValueW'({$urandom(), $urandom()});
      end
    endcase
    // shaped magnitudes get a random sign
    if ($urandom_range(0, 1) == 1) begin
      v = ~v + 1'b1;
    end
    return v;
  endfunction

  // offer one number and hold it until it is taken; valid stays high for a back-to-back request
  task automatic send_number(input logic [ValueW-1:0] num);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    value    = num;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop offering and wait until every expected character has come back
  task automatic settle();
    in_valid = 1'b0;
    while (chars_due != 0) @(negedge clk);
  endtask

  // register write, only ever issued while the block is idle
  task automatic set_radix(input logic [RadixW-1:0] r);
    radix_we = 1'b1;
    radix    = r;
    @(negedge clk);
    radix_we = 1'b0;
  endtask

  // character receiver: random stalls, one long hold-off on request, none in steady phases
  initial begin
    int unsigned stall_left;
    logic        held;
    stall_left = 0;
    held       = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && !held) begin
        held      = 1'b1;
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall = 1'b0;
      end else if (stall_left != 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // watchdog: ends the run once neither channel has moved for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    logic [RadixW-1:0] r;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    value    = '0;
    radix_we = 1'b0;
    radix    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset base of ten: zero, unit values, both extremes, a two-digit negative
    send_number('0);
    send_number(ValueW'(1));
    send_number(NumNeg1);
    send_number(NumMax);
    send_number(NumMin);
    send_number(ValueW'(7));
    send_number(-ValueW'(10));
    send_number(ValueW'(100));
    settle();

    // base 2: longest texts, including the most negative value with its sign
    set_radix(RadixW'(2));
    send_number('0);
    send_number(NumMax);
    send_number(NumMin);
    send_number(NumNeg1);
    send_number(ValueW'(6));
    settle();

    // base 36: highest letter digit and the roll-over into two digits
    set_radix(RadixW'(36));
    send_number(ValueW'(35));
    send_number(ValueW'(36));
    send_number(-ValueW'(35));
    send_number(NumMin);
    send_number(NumMax);
    settle();

    set_radix(RadixW'(16));
    send_number(ValueW'(255));
    send_number(-ValueW'(256));
    settle();

    // invalid bases on either side of the legal range, all-zero and all-one register
    set_radix(RadixW'(0));
    send_number(ValueW'(5));
    settle();
    set_radix(RadixW'(1));
    send_number(-ValueW'(5));
    settle();
    set_radix(RadixW'(37));
    send_number(NumMin);
    settle();
    set_radix(RadixW'(63));
    send_number('0);
    settle();

    // random phases, each under a fresh base
    sent = 0;
    for (phase = 0; sent < RandomItems; phase++) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 2))
            0: r = RadixW'(0);
            1: r = RadixW'(1);
            default: r = RadixW'($urandom_range(37, 63));
          endcase
        end
        1: r = RadixW'(2);
        2: r = RadixW'(36);
        3: r = RadixW'(16);
        default: r = RadixW'($urandom_range(2, 36));
      endcase
      set_radix(r);
      no_gaps = (phase % 7 == 5);
      // one phase starts with the receiver held off so the block backs up onto its input
      if (phase == 3) begin
        hold_off = 1'b1;
      end
      n = $urandom_range(15, 30);
      repeat (n) begin
        send_number(pick_value());
        sent++;
      end
      settle();
    end
    no_gaps = 1'b0;

    settle();
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0 && chars_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
